[sv/itra_pkg.sv]
// Package for the integer to radix ASCII converter.
// Holds the transaction types, character constants and the digit encoder.
// Used by the top level, itra_front and itra_back.
`default_nettype none
package itra_pkg;

  localparam int ValueWidth = 64;
  localparam int CmdDepth   = 2;
  localparam int ResDepth   = 2;

  localparam logic [5:0] RadixMin = 6'd2;
  localparam logic [5:0] RadixMax = 6'd36;
  localparam logic [5:0] RadixDec = 6'd10;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharAlpha = 8'h61;
  localparam logic [7:0] CharMinus = 8'h2d;

  typedef struct packed {
    logic [63:0] value_bits;
    logic        is_signed;
    logic [5:0]  radix;
  } in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic       bad_radix;
  } out_t;

  typedef struct packed {
    logic       bad;
    logic       neg_dec;
    logic [5:0] radix;
  } cmd_ctl_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [7:0] d8;
    begin
      d8 = {2'b00, d};
      if (d < RadixDec) begin
        digit_char = CharZero + d8;
      end else begin
        digit_char = CharAlpha + d8 - {2'b00, RadixDec};
      end
    end
  endfunction

endpackage
`default_nettype wire

[sv/integer_to_radix_ascii_core.sv]
// Top level of the integer to radix ASCII converter.
// Depends on itra_pkg, itra_front, itra_queue, itra_back (itra_ram).
//
// Converts a VALUE_WIDTH-bit number, signed or unsigned, to lower-case ASCII
// digits in a radix from 2 to 36, most significant digit first, one character
// per result transaction with last_char on the final one. Signed negative
// decimal values get a leading '-'; other radices give the magnitude. A radix
// outside 2..36 yields a single result with bad_radix set and char_code 0.
// Each digit comes from the one-bit-per-cycle restoring divider, and each
// character is then read back from the digit stack RAM and emitted. A
// two-entry command queue and a two-entry result queue let input and output
// stall independently.
`default_nettype none
module integer_to_radix_ascii_core #(
  parameter int VALUE_WIDTH = itra_pkg::ValueWidth
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire itra_pkg::in_t  operand,
  input  wire logic           pop,
  output logic                empty,
  output itra_pkg::out_t      result
);

  localparam int CW = VALUE_WIDTH + $bits(itra_pkg::cmd_ctl_t);
  localparam int RW = $bits(itra_pkg::out_t);

  itra_pkg::cmd_ctl_t     fe_ctl;
  logic [VALUE_WIDTH-1:0] fe_mag;
  logic [CW-1:0]          cq_rdata;
  logic                   cq_empty;
  logic                   cq_pop;
  itra_pkg::cmd_ctl_t     be_ctl;
  logic [VALUE_WIDTH-1:0] be_mag;
  logic                   res_push;
  itra_pkg::out_t         res;
  logic                   res_full;
  logic [RW-1:0]          rq_rdata;

  itra_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .operand(operand),
    .ctl    (fe_ctl),
    .mag    (fe_mag)
  );

  itra_queue #(.WIDTH(CW), .DEPTH(itra_pkg::CmdDepth)) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata({fe_ctl, fe_mag}),
    .full (full),
    .pop  (cq_pop),
    .rdata(cq_rdata),
    .empty(cq_empty)
  );

  assign be_ctl = cq_rdata[CW-1:VALUE_WIDTH];
  assign be_mag = cq_rdata[VALUE_WIDTH-1:0];

  itra_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(!cq_empty),
    .cmd_ctl  (be_ctl),
    .cmd_mag  (be_mag),
    .cmd_pop  (cq_pop),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  itra_queue #(.WIDTH(RW), .DEPTH(itra_pkg::ResDepth)) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (pop),
    .rdata(rq_rdata),
    .empty(empty)
  );

  assign result = rq_rdata;

endmodule
`default_nettype wire

[sv/itra_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module itra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/itra_queue.sv]
// Small first-in first-out queue of flat words.
// No dependencies.
`default_nettype none
module itra_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

[sv/itra_front.sv]
// Front end: classifies an incoming number (radix check, sign, magnitude).
// Depends on itra_pkg.
`default_nettype none
module itra_front #(
  parameter int VALUE_WIDTH = itra_pkg::ValueWidth
) (
  input  wire itra_pkg::in_t       operand,
  output itra_pkg::cmd_ctl_t       ctl,
  output logic [VALUE_WIDTH-1:0]   mag
);

  logic [VALUE_WIDTH-1:0] v;
  logic                   neg;

  assign v   = operand.value_bits[VALUE_WIDTH-1:0];
  assign neg = operand.is_signed && v[VALUE_WIDTH-1];
  assign mag = neg ? (~v + 1'b1) : v;

  always_comb begin
    ctl.bad     = (operand.radix < itra_pkg::RadixMin) || (operand.radix > itra_pkg::RadixMax);
    ctl.neg_dec = neg && (operand.radix == itra_pkg::RadixDec);
    ctl.radix   = operand.radix;
  end

endmodule
`default_nettype wire

[sv/itra_back.sv]
// Back end: serial restoring divider producing digits into a stack RAM,
// then emission most significant first. Depends on itra_pkg, itra_ram.
`default_nettype none
module itra_back #(
  parameter int VALUE_WIDTH = itra_pkg::ValueWidth
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cmd_valid,
  input  wire itra_pkg::cmd_ctl_t      cmd_ctl,
  input  wire logic [VALUE_WIDTH-1:0]  cmd_mag,
  output logic                         cmd_pop,
  output logic                         res_push,
  output itra_pkg::out_t               res,
  input  wire logic                    res_full
);

  localparam int AW = $clog2(VALUE_WIDTH);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIV     = 3'd1;
  localparam logic [2:0] S_SIGN    = 3'd2;
  localparam logic [2:0] S_EMIT_RD = 3'd3;
  localparam logic [2:0] S_EMIT_WR = 3'd4;
  localparam logic [2:0] S_BAD     = 3'd5;

  logic [2:0]             state;
  logic [VALUE_WIDTH-1:0] dvd;
  logic [5:0]             rem;
  logic [5:0]             radix;
  logic                   neg_dec;
  logic [AW-1:0]          bitcnt;
  logic [AW-1:0]          cnt;
  logic [AW-1:0]          idx;

  logic [6:0]             rem_sh;
  logic                   ge;
  logic [6:0]             rem_sub;
  logic [5:0]             rem_next;
  logic [VALUE_WIDTH-1:0] dvd_next;
  logic                   last_bit;
  logic                   ram_we;
  logic [5:0]             ram_rdata;

  assign rem_sh   = {rem, dvd[VALUE_WIDTH-1]};
  assign ge       = rem_sh >= {1'b0, radix};
  assign rem_sub  = rem_sh - {1'b0, radix};
  assign rem_next = ge ? rem_sub[5:0] : rem_sh[5:0];
  assign dvd_next = {dvd[VALUE_WIDTH-2:0], ge};
  assign last_bit = (bitcnt == AW'(VALUE_WIDTH - 1));
  assign ram_we   = (state == S_DIV) && last_bit;
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;

  itra_ram #(
    .WIDTH(6),
    .DEPTH(VALUE_WIDTH)
  ) u_digits (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt),
    .wdata(rem_next),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  always_comb begin
    res_push      = 1'b0;
    res.char_code = '0;
    res.last_char = 1'b0;
    res.bad_radix = 1'b0;
    unique case (state)
      S_BAD: begin
        res_push      = !res_full;
        res.last_char = 1'b1;
        res.bad_radix = 1'b1;
      end
      S_SIGN: begin
        res_push      = !res_full;
        res.char_code = itra_pkg::CharMinus;
      end
      S_EMIT_WR: begin
        res_push      = !res_full;
        res.char_code = itra_pkg::digit_char(ram_rdata);
        res.last_char = (idx == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= cmd_ctl.bad ? S_BAD : S_DIV;
          end
        end
        S_DIV: begin
          if (last_bit && (dvd_next == '0)) begin
            state <= neg_dec ? S_SIGN : S_EMIT_RD;
          end
        end
        S_SIGN: begin
          if (!res_full) begin
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WR;
        end
        S_EMIT_WR: begin
          if (!res_full) begin
            state <= (idx == '0) ? S_IDLE : S_EMIT_RD;
          end
        end
        S_BAD: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      dvd     <= cmd_mag;
      rem     <= '0;
      radix   <= cmd_ctl.radix;
      neg_dec <= cmd_ctl.neg_dec;
      bitcnt  <= '0;
      cnt     <= '0;
    end else if (state == S_DIV) begin
      dvd <= dvd_next;
      if (last_bit) begin
        rem    <= '0;
        bitcnt <= '0;
        cnt    <= cnt + 1'b1;
        idx    <= cnt;
      end else begin
        rem    <= rem_next;
        bitcnt <= bitcnt + 1'b1;
      end
    end else if (state == S_EMIT_WR && !res_full && idx != '0) begin
      idx <= idx - 1'b1;
    end
  end

endmodule
`default_nettype wire
